[sv/tgd_pkg.sv]
// Shared types and constants for the tile grid derivation block.
`timescale 1ns / 1ps

package tgd_pkg;

    // Fixed field widths.
    localparam int POS_W = 11;
    localparam int SIZE_M1_W = 10;
    localparam int IDX_W = 5;

    // Results one input transaction may produce.
    localparam int RESULT_SLOTS = 32;
    localparam int N_W = $clog2(RESULT_SLOTS);

    // Configuration register indexes.
    localparam logic REG_PIC_WIDTH = 1'b0;
    localparam logic REG_PIC_HEIGHT = 1'b1;

    // Axis codes.
    localparam logic AXIS_COL = 1'b0;
    localparam logic AXIS_ROW = 1'b1;

    // Input transaction payload.
    typedef struct packed {
        logic                 axis;
        logic [SIZE_M1_W-1:0] size_minus1;
        logic                 last_explicit;
    } tgd_in_t;

    // Output transaction payload.
    typedef struct packed {
        logic             out_axis;
        logic [IDX_W-1:0] tile_index;
        logic [POS_W-1:0] tile_size;
        logic [POS_W-1:0] tile_start;
        logic             last;
        logic             overflow;
    } tgd_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } tgd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_final;
    } tgd_status_t;

endpackage

[sv/tgd_ctrl.sv]
// Controller for the tile grid derivation: sequencing and handshakes.
`timescale 1ns / 1ps

module tgd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  tgd_pkg::tgd_status_t status,
    output tgd_pkg::tgd_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic step_fire;
    logic load;

    // A step runs when an item is held and the output register is free or draining.
    assign step_fire = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);

    // A new item is taken when idle or in the cycle that finishes the current one.
    assign in_ready = (state_reg == ST_IDLE) || (step_fire && status.step_final);
    assign load = in_valid && in_ready;

    assign cmd.load = load;
    assign cmd.step = step_fire;
    assign out_valid = out_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (load)
        begin
            state_next = ST_RUN;
        end
        else if (step_fire && status.step_final)
        begin
            state_next = ST_IDLE;
        end
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/tgd_dp.sv]
// Datapath for the tile grid derivation: axis state, tile arithmetic, output register.
`timescale 1ns / 1ps

module tgd_dp
#(
    parameter int MAX_TILES = 32,
    parameter int CTB_COORD_BITS = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [tgd_pkg::POS_W-1:0]    cfg_data,
    input  tgd_pkg::tgd_in_t             in_data,
    input  tgd_pkg::tgd_cmd_t            cmd,
    output tgd_pkg::tgd_status_t         status,
    output tgd_pkg::tgd_out_t            out_data
);

    localparam int POS_W = tgd_pkg::POS_W;
    localparam int CNT_W = $clog2(MAX_TILES + 1);
    localparam int N_W = tgd_pkg::N_W;
    localparam logic [POS_W:0] PIC_LIMIT =
        (CTB_COORD_BITS >= POS_W) ? (POS_W+1)'(1 << POS_W) : (POS_W+1)'(1 << CTB_COORD_BITS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TILES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TILES - 1);
    localparam logic [tgd_pkg::IDX_W-1:0] MARK_IDX = tgd_pkg::IDX_W'(MAX_TILES - 1);
    localparam logic [N_W-1:0] N_LAST = N_W'(tgd_pkg::RESULT_SLOTS - 1);

    // Configuration registers.
    logic [POS_W-1:0] pic_w_reg;
    logic [POS_W-1:0] pic_h_reg;

    // Per-axis state.
    logic [POS_W-1:0] next_start_reg [2];
    logic [CNT_W-1:0] tile_count_reg [2];
    logic             ovf_seen_reg [2];

    // Current item and its progress.
    logic             item_axis_reg;
    logic [POS_W-1:0] item_sz_reg;
    logic             item_fill_reg;
    logic             phase_reg;
    logic [N_W-1:0]   n_reg;
    tgd_pkg::tgd_out_t out_reg;

    // Step arithmetic.
    logic [POS_W-1:0] pic_raw;
    logic [POS_W-1:0] pic;
    logic [POS_W-1:0] ns;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
    logic [POS_W-1:0] rem;
    logic             full;
    logic             sz_gt;
    logic [POS_W-1:0] t_min;
    logic             force_all;
    logic [POS_W-1:0] t;
    logic             clamp;
    logic [POS_W-1:0] rem_after;
    logic             final_step;
    logic             ovf_new;
    logic [31:0]      cnt_wide;
    tgd_pkg::tgd_out_t res;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pic_w_reg <= POS_W'(1);
            pic_h_reg <= POS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tgd_pkg::REG_PIC_WIDTH:  pic_w_reg <= cfg_data;
                tgd_pkg::REG_PIC_HEIGHT: pic_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Picture size for the current axis, clamped to the coordinate range.
    always_comb
    begin
        pic_raw = (item_axis_reg == tgd_pkg::AXIS_ROW) ? pic_h_reg : pic_w_reg;
        pic = ({1'b0, pic_raw} > PIC_LIMIT) ? PIC_LIMIT[POS_W-1:0] : pic_raw;
    end

    // One tile per step: the explicit tile first, then the uniform fill tiles.
    always_comb
    begin
        ns = next_start_reg[item_axis_reg];
        cnt = tile_count_reg[item_axis_reg];
        ovf = ovf_seen_reg[item_axis_reg];
        rem = (pic > ns) ? (pic - ns) : '0;
        full = (cnt >= CNT_MAX);
        sz_gt = (item_sz_reg > rem);
        t_min = sz_gt ? rem : item_sz_reg;
        force_all = phase_reg && (rem != t_min) && ((cnt >= CNT_LAST) || (n_reg == N_LAST));
        t = force_all ? rem : t_min;
        clamp = phase_reg ? force_all : sz_gt;
        rem_after = full ? rem : (rem - t);
        final_step = (phase_reg && full) || !item_fill_reg || (rem_after == '0);
        ovf_new = ovf || full || clamp;
        cnt_wide = 32'(cnt);

        res.out_axis = item_axis_reg;
        res.tile_index = full ? MARK_IDX : cnt_wide[tgd_pkg::IDX_W-1:0];
        res.tile_size = full ? '0 : t;
        res.tile_start = ns;
        res.last = item_fill_reg && final_step;
        res.overflow = ovf_new;
    end

    assign status.step_final = final_step;
    assign out_data = out_reg;

    // Per-axis state and item progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 2; a++)
            begin
                next_start_reg[a] <= '0;
                tile_count_reg[a] <= '0;
                ovf_seen_reg[a] <= 1'b0;
            end
            phase_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                if (item_fill_reg && final_step)
                begin
                    next_start_reg[item_axis_reg] <= '0;
                    tile_count_reg[item_axis_reg] <= '0;
                    ovf_seen_reg[item_axis_reg] <= 1'b0;
                end
                else
                begin
                    ovf_seen_reg[item_axis_reg] <= ovf_new;
                    if (!full)
                    begin
                        next_start_reg[item_axis_reg] <= ns + t;
                        tile_count_reg[item_axis_reg] <= cnt + CNT_W'(1);
                    end
                end
            end
            // A newly loaded item starts over; otherwise a step advances the progress.
            if (cmd.load)
            begin
                phase_reg <= 1'b0;
                n_reg <= '0;
            end
            else if (cmd.step)
            begin
                phase_reg <= 1'b1;
                n_reg <= n_reg + N_W'(1);
            end
        end
    end

    // Item and output payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_axis_reg <= in_data.axis;
            item_sz_reg <= POS_W'(in_data.size_minus1) + POS_W'(1);
            item_fill_reg <= in_data.last_explicit;
        end
        if (cmd.step)
        begin
            out_reg <= res;
        end
    end

endmodule

[sv/tile_grid_derivation.sv]
// Tile grid derivation: emits the tile columns or rows of a picture from explicit sizes.
//
// Usage: the input channel (in_valid/in_ready/in_data) carries one explicit tile size
// for one axis. Each input transaction yields one output transaction for that tile;
// when last_explicit is set it further yields uniform tiles of the same size and a
// remainder tile, one per cycle unless the output stalls, then clears that axis.
// Picture sizes come from the write port (cfg_we/cfg_index/cfg_data); the user writes
// them only while the block is idle, which the block itself does not enforce.
// The final tile is marked last. After an accept the controller enters its run state;
// the first step runs once the output register is free, and its result is then held in
// the output register. Throughput: one step per cycle while the output is not stalled,
// each step producing one output transaction, so an explicit entry takes one step and a
// last entry one step per tile; the next input is taken in the cycle of the final step.
// The output register is the only buffer: while it holds a result and out_ready is low
// no step runs and the held result stays put, so the whole block waits.
// Reset: both picture sizes return to 1 CTB and both axes to an empty grid; no
// clearing pass is needed.
`timescale 1ns / 1ps

module tile_grid_derivation
#(
    parameter int MAX_TILES = 32,
    parameter int CTB_COORD_BITS = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [tgd_pkg::POS_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  tgd_pkg::tgd_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output tgd_pkg::tgd_out_t         out_data
);

    tgd_pkg::tgd_cmd_t    cmd;
    tgd_pkg::tgd_status_t status;

    // Sequencing and handshakes.
    tgd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Tile arithmetic and state.
    tgd_dp
    #(
        .MAX_TILES      (MAX_TILES),
        .CTB_COORD_BITS (CTB_COORD_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    // A tile of size zero is only ever a clamped tile or a marker.
    a_zero_size_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.tile_size == '0) |-> out_data.overflow)
        else $error("zero-size tile without overflow");

    // The closing tile of an axis either covers CTBs or reports an overflow.
    a_last_tile: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last && !out_data.overflow |-> (out_data.tile_size != '0))
        else $error("empty closing tile without overflow");

    // After a step runs, the output register holds its result as valid.
    a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> out_valid)
        else $error("result lost after step");

endmodule
